// ===== hdl/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared constants for the grid segment collision checker: item kinds,
// register indexes and the divider geometry.
// ----------------------------------------------------------------------------
package gsc_pkg;

    // item kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_SEG   = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MAP_LOADED = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd2;
    localparam logic [2:0] REG_RESOLUTION = 3'd3;
    localparam logic [2:0] REG_SIZE_X     = 3'd4;
    localparam logic [2:0] REG_SIZE_Y     = 3'd5;
    localparam logic [2:0] REG_THRESHOLD  = 3'd6;

    // divider: dividend / quotient width and divisor width
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 34;

endpackage

// ===== hdl/gsc_ram.sv =====
// ----------------------------------------------------------------------------
// gsc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module gsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gsc_div.sv =====
// ----------------------------------------------------------------------------
// gsc_div
// Unsigned restoring divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses when the quotient is ready and it then holds.
// ----------------------------------------------------------------------------
module gsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gsc_pkg::DIV_NW-1:0]  i_num,
    input  logic [gsc_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_done,
    output logic [gsc_pkg::DIV_NW-1:0]  o_quo
);
    import gsc_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // shift in next dividend bit, subtract when it fits
    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // done is a single pulse per division
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    // done only ends a running division
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    // busy and done never overlap
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done)) else $error("divider busy during done");

endmodule

// ===== hdl/grid_segment_collision_check.sv =====
// ----------------------------------------------------------------------------
// grid_segment_collision_check
// Byte cost grid with point and segment (line of sight) collision queries.
// ----------------------------------------------------------------------------
// Use: drive an item on the i_ fields and raise start; it is taken at a clock
// edge where start is high and busy is low. A cell write (kind 0) stores its
// cost in the grid RAM that same edge and gives no result; kind 3 is dropped.
// A query gives one result beat: o_valid high for one cycle with o_collides.
// The receiver cannot stall; the beat must be taken when shown.
// With no map loaded a query answers on the next cycle. A point query runs
// two dividers in parallel to map x and y to cells, then one grid read. A
// segment query adds a setup (two squares on the shared multiplier, a 33-step
// root, the step count division, the direction divisions, two multiplies) and
// then one point check per sample, each by the divider pair and the RAM read,
// for up to floor(dist/resolution)-1 samples, or the end point alone when that
// quotient is zero. One item is in work at a time.
// Reset sets the configuration registers to their defaults; the grid RAM is
// not cleared and a cell must be written before a query reads it.
// Configuration: APB-style port, register i at byte address 4*i, always
// ready; the user must write it only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
module grid_segment_collision_check #(
    parameter int MAX_CELLS_X = 256,
    parameter int MAX_CELLS_Y = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_cell_x,
    input  logic [7:0]         i_cell_y,
    input  logic [7:0]         i_cell_cost,
    input  logic signed [31:0] i_from_x,
    input  logic signed [31:0] i_from_y,
    input  logic signed [31:0] i_to_x,
    input  logic signed [31:0] i_to_y,
    // result
    output logic               o_valid,
    output logic               o_collides,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gsc_pkg::*;

    localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_CELLS_X);
    localparam int YW    = $clog2(MAX_CELLS_Y);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ1   = 4'd1;
    localparam logic [3:0] S_SQ2   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_SDIV  = 4'd4;
    localparam logic [3:0] S_SDIVW = 4'd5;
    localparam logic [3:0] S_UDIV  = 4'd6;
    localparam logic [3:0] S_UDIVW = 4'd7;
    localparam logic [3:0] S_MX    = 4'd8;
    localparam logic [3:0] S_MY    = 4'd9;
    localparam logic [3:0] S_LOOP  = 4'd10;
    localparam logic [3:0] S_PDIV  = 4'd11;
    localparam logic [3:0] S_PDIVW = 4'd12;
    localparam logic [3:0] S_PCHK  = 4'd13;
    localparam logic [3:0] S_PRD   = 4'd14;

    // configuration registers
    logic               r_map_loaded;
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_resolution;
    logic [8:0]         r_size_x;
    logic [8:0]         r_size_y;
    logic [7:0]         r_threshold;

    // control and datapath registers
    logic [3:0]         r_state;
    logic               r_valid;
    logic               r_collides;
    logic               r_loop;
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic [32:0]        r_ax;
    logic [32:0]        r_ay;
    logic               r_negx;
    logic               r_negy;
    logic [65:0]        r_sum;
    logic [34:0]        r_rem;
    logic [32:0]        r_root;
    logic [5:0]         r_cnt;
    logic [33:0]        r_steps;
    logic [33:0]        r_n;
    logic [30:0]        r_ux;
    logic [30:0]        r_uy;
    logic [63:0]        r_rux;
    logic [63:0]        r_ruy;
    logic [63:0]        r_accx;
    logic [63:0]        r_accy;
    logic signed [35:0] r_px;
    logic signed [35:0] r_py;

    logic               accept;
    logic               cfg_wr;
    logic [31:0]        eres;
    logic [32:0]        m_a;
    logic [32:0]        m_b;
    logic [65:0]        m_p;
    logic [36:0]        sq_t;
    logic [36:0]        sq_trial;
    logic               sq_ge;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [36:0] numx;
    logic signed [36:0] numy;
    logic [36:0]        absx;
    logic [36:0]        absy;
    logic [63:0]        sx64;
    logic [63:0]        sy64;
    logic               outside;
    logic               hit;
    logic [33:0]        offx;
    logic [33:0]        offy;

    logic               d_start;
    logic [DIV_NW-1:0]  d0_num;
    logic [DIV_NW-1:0]  d1_num;
    logic [DIV_DW-1:0]  d0_den;
    logic [DIV_DW-1:0]  d1_den;
    logic               d0_done;
    logic               d1_done;
    logic [DIV_NW-1:0]  q0;
    logic [DIV_NW-1:0]  q1;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign eres   = (r_resolution == 32'd0) ? 32'd1 : r_resolution;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_loaded <= 1'b0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_resolution <= 32'd3277;
            r_size_x     <= 9'd256;
            r_size_y     <= 9'd256;
            r_threshold  <= 8'd200;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MAP_LOADED: r_map_loaded <= pwdata[0];
                REG_ORIGIN_X:   r_origin_x   <= $signed(pwdata);
                REG_ORIGIN_Y:   r_origin_y   <= $signed(pwdata);
                REG_RESOLUTION: r_resolution <= pwdata;
                REG_SIZE_X:     r_size_x     <= pwdata[8:0];
                REG_SIZE_Y:     r_size_y     <= pwdata[8:0];
                REG_THRESHOLD:  r_threshold  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_MAP_LOADED: prdata = {31'd0, r_map_loaded};
            REG_ORIGIN_X:   prdata = r_origin_x;
            REG_ORIGIN_Y:   prdata = r_origin_y;
            REG_RESOLUTION: prdata = r_resolution;
            REG_SIZE_X:     prdata = {23'd0, r_size_x};
            REG_SIZE_Y:     prdata = {23'd0, r_size_y};
            REG_THRESHOLD:  prdata = {24'd0, r_threshold};
            default:        prdata = 32'd0;
        endcase
    end

    // shared multiplier: squares, then resolution times direction
    always_comb begin
        case (r_state)
            S_SQ1:   begin m_a = r_ax; m_b = r_ax; end
            S_SQ2:   begin m_a = r_ay; m_b = r_ay; end
            S_MX:    begin m_a = {1'b0, eres}; m_b = {2'b0, r_ux}; end
            default: begin m_a = {1'b0, eres}; m_b = {2'b0, r_uy}; end
        endcase
    end
    assign m_p = m_a * m_b;

    // root step: two radicand bits per cycle
    assign sq_t     = {r_rem, r_sum[65:64]};
    assign sq_trial = {2'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // segment deltas at accept
    assign dx = 33'(i_to_x) - 33'(i_from_x);
    assign dy = 33'(i_to_y) - 33'(i_from_y);

    // point to cell: signed offset from origin, divided as magnitude
    assign numx = 37'(r_px) - 37'(r_origin_x);
    assign numy = 37'(r_py) - 37'(r_origin_y);
    assign absx = numx[36] ? 37'(-numx) : numx;
    assign absy = numy[36] ? 37'(-numy) : numy;

    // divider operands
    always_comb begin
        d_start = 1'b0;
        d0_num  = 64'(absx);
        d1_num  = 64'(absy);
        d0_den  = 34'(eres);
        d1_den  = 34'(eres);
        case (r_state)
            S_SDIV: begin
                d_start = 1'b1;
                d0_num  = 64'(r_root);
            end
            S_UDIV: begin
                d_start = 1'b1;
                d0_num  = {1'b0, r_ax, 30'd0};
                d1_num  = {1'b0, r_ay, 30'd0};
                d0_den  = {1'b0, r_root};
                d1_den  = {1'b0, r_root};
            end
            S_PDIV: d_start = 1'b1;
            default: ;
        endcase
    end

    gsc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d0_num),
        .i_den   (d0_den),
        .o_done  (d0_done),
        .o_quo   (q0)
    );

    gsc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .o_done  (d1_done),
        .o_quo   (q1)
    );

    // bounds against the used grid, clamped to the RAM geometry
    assign sx64 = (64'(r_size_x) > 64'(MAX_CELLS_X)) ? 64'(MAX_CELLS_X) : 64'(r_size_x);
    assign sy64 = (64'(r_size_y) > 64'(MAX_CELLS_Y)) ? 64'(MAX_CELLS_Y) : 64'(r_size_y);
    assign outside = (numx[36] && (q0 != 64'd0)) || (numy[36] && (q1 != 64'd0)) ||
                     (q0 >= sx64) || (q1 >= sy64);
    assign hit = ram_rdata >= r_threshold;

    // grid RAM
    assign ram_we    = accept && (i_kind == KIND_CELL) &&
                       (32'(i_cell_x) < 32'(MAX_CELLS_X)) &&
                       (32'(i_cell_y) < 32'(MAX_CELLS_Y));
    assign ram_waddr = AW'(i_cell_y) * AW'(MAX_CELLS_X) + AW'(i_cell_x);
    assign ram_raddr = AW'(q1[YW-1:0]) * AW'(MAX_CELLS_X) + AW'(q0[XW-1:0]);

    gsc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cell_cost),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sample offsets toward the end point
    assign offx = r_accx[63:30];
    assign offy = r_accy[63:30];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_kind == KIND_POINT) begin
                        if (!r_map_loaded) begin
                            r_valid    <= 1'b1;
                            r_collides <= 1'b0;
                        end else begin
                            r_px    <= 36'(i_from_x);
                            r_py    <= 36'(i_from_y);
                            r_loop  <= 1'b0;
                            r_state <= S_PDIV;
                        end
                    end else if (accept && i_kind == KIND_SEG) begin
                        if (!r_map_loaded) begin
                            r_valid    <= 1'b1;
                            r_collides <= 1'b0;
                        end else begin
                            r_fx    <= i_from_x;
                            r_fy    <= i_from_y;
                            r_tx    <= i_to_x;
                            r_ty    <= i_to_y;
                            r_negx  <= dx[32];
                            r_negy  <= dy[32];
                            r_ax    <= dx[32] ? 33'(-dx) : dx;
                            r_ay    <= dy[32] ? 33'(-dy) : dy;
                            r_state <= S_SQ1;
                        end
                    end
                end
                S_SQ1: begin
                    r_sum   <= m_p;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sum   <= r_sum + m_p;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rem  <= sq_ge ? 35'(sq_t - sq_trial) : sq_t[34:0];
                    r_root <= {r_root[31:0], sq_ge};
                    r_sum  <= {r_sum[63:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 6'd32) begin
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: r_state <= S_SDIVW;
                S_SDIVW: begin
                    if (d0_done) begin
                        r_steps <= q0[33:0];
                        if (q0[33:0] == 34'd0) begin
                            r_px    <= 36'(r_tx);
                            r_py    <= 36'(r_ty);
                            r_loop  <= 1'b0;
                            r_state <= S_PDIV;
                        end else begin
                            r_state <= S_UDIV;
                        end
                    end
                end
                S_UDIV: r_state <= S_UDIVW;
                S_UDIVW: begin
                    if (d0_done) begin
                        r_ux    <= q0[30:0];
                        r_uy    <= q1[30:0];
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_rux   <= m_p[63:0];
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_ruy   <= m_p[63:0];
                    r_accx  <= r_rux;
                    r_accy  <= m_p[63:0];
                    r_n     <= 34'd1;
                    r_loop  <= 1'b1;
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_n >= r_steps) begin
                        r_valid    <= 1'b1;
                        r_collides <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_px    <= r_negx ? 36'(r_fx) - 36'(offx) : 36'(r_fx) + 36'(offx);
                        r_py    <= r_negy ? 36'(r_fy) - 36'(offy) : 36'(r_fy) + 36'(offy);
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: r_state <= S_PDIVW;
                S_PDIVW: begin
                    if (d0_done) begin
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    if (outside) begin
                        r_valid    <= 1'b1;
                        r_collides <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    if (r_loop && !hit) begin
                        r_n     <= r_n + 1'b1;
                        r_accx  <= r_accx + r_rux;
                        r_accy  <= r_accy + r_ruy;
                        r_state <= S_LOOP;
                    end else begin
                        r_valid    <= 1'b1;
                        r_collides <= hit;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_collides = r_collides;

    // a result beat always leaves the block idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy) else $error("result while busy");
    // busy starts only from an accepted command
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");
    // sample loop never runs on a zero index
    a_loop_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_n != 34'd0)) else $error("zero sample index");
    // both cell dividers finish together
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d0_done == d1_done) else $error("divider pair out of step");

endmodule
